// ----- src/hskp_pkg.sv -----
package hskp_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_W = 16;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] sorted_key;
    logic [PAY_W-1:0]        sorted_payload;
    logic                    final_res;
    logic                    dropped;
  } result_t;

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_NEXT   = 8'b0000_0010,
    S_HOLD   = 8'b0000_0100,
    S_SWAP   = 8'b0000_1000,
    S_CHILD  = 8'b0001_0000,
    S_CMP    = 8'b0010_0000,
    S_OUT_RD = 8'b0100_0000,
    S_OUT_LD = 8'b1000_0000
  } state_t;

endpackage

// ----- src/heap_sort_key_payload.sv -----
// Collects (key, payload) pairs, one per cycle, into a store of MAX_ITEMS
// entries; the transaction marked last starts an in-place heapsort in
// ascending signed key order, after which every stored pair is emitted, the
// final one flagged, all of them flagged dropped if the set overflowed the store
// (excess items are discarded, a last item too, yet the sort still runs). Equal
// keys leave in a fixed order set by the max-heap procedure. A new item may
// enter while a result still waits. The sort runs over a store with two
// registered read ports and one write port: each outer step of the build and
// extraction phases reads an entry and holds it (in extraction after moving
// the root to the end), then sifts it down one heap level per child read and
// compare. Each result is read from the store and then loaded for output,
// waiting while res_stall holds the one before. No item is accepted from the
// last item until the final result is loaded for output.
module heap_sort_key_payload #(
  parameter int MAX_ITEMS    = 64,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  hskp_pkg::item_t  item,
  output logic             res_valid,
  input  logic             res_stall,
  output hskp_pkg::result_t res
);
  import hskp_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = AW + 2;
  localparam int PW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;

  logic signed [KEY_W-1:0] key_mem [MAX_ITEMS];
  logic [PW-1:0]           pay_mem [MAX_ITEMS];

  state_t                  state;
  logic [CW-1:0]           item_count;
  logic                    overflow_seen;
  logic [CW-1:0]           n_reg;
  logic [CW-1:0]           i_reg;
  logic [AW-1:0]           parent;
  logic [AW-1:0]           child_reg;
  logic                    right_in;
  logic [AW-1:0]           k_reg;
  logic signed [KEY_W-1:0] hold_key;
  logic [PW-1:0]           hold_pay;
  logic signed [KEY_W-1:0] rd_key_a;
  logic signed [KEY_W-1:0] rd_key_b;
  logic [PW-1:0]           rd_pay_a;
  logic [PW-1:0]           rd_pay_b;
  result_t                 res_data;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic signed [KEY_W-1:0] wkey;
  logic [PW-1:0]           wpay;
  logic                    re;
  logic [AW-1:0]           ra;
  logic [AW-1:0]           rb;

  logic                    full;
  logic [CW-1:0]           load_count;
  logic [IW-1:0]           child_ix;
  logic [IW-1:0]           child1;
  logic [IW-1:0]           n_ext;
  logic                    right_sel;
  logic signed [KEY_W-1:0] big_key;
  logic [PW-1:0]           big_pay;
  logic [AW-1:0]           big_ix;
  logic                    take;
  logic                    last_k;
  logic                    out_free;

  assign full       = (item_count == CW'(MAX_ITEMS));
  assign load_count = full ? item_count : item_count + CW'(1);
  assign child_ix   = IW'({parent, 1'b1});
  assign child1     = child_ix + IW'(1);
  assign n_ext      = IW'(n_reg);
  assign right_sel  = right_in && (rd_key_b > rd_key_a);
  assign big_key    = right_sel ? rd_key_b : rd_key_a;
  assign big_pay    = right_sel ? rd_pay_b : rd_pay_a;
  assign big_ix     = right_sel ? child_reg + AW'(1) : child_reg;
  assign take       = (big_key > hold_key);
  assign last_k     = ((CW'(k_reg) + CW'(1)) == item_count);
  assign out_free   = !res_valid || !res_stall;

  assign item_stall = (state != S_LOAD);
  assign res        = res_data;

  // store port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wkey  = '0;
    wpay  = '0;
    re    = 1'b0;
    ra    = '0;
    rb    = '0;
    case (state)
      S_LOAD: begin
        if (item_valid && !full) begin
          we    = 1'b1;
          waddr = item_count[AW-1:0];
          wkey  = item.key;
          wpay  = item.payload[PW-1:0];
        end
      end
      S_NEXT: begin
        re = 1'b1;
        if (i_reg != '0) begin
          ra = AW'(i_reg - CW'(1));
        end else begin
          ra = AW'(n_reg - CW'(1));
        end
      end
      S_SWAP: begin
        we    = 1'b1;
        waddr = AW'(n_reg);
        wkey  = rd_key_b;
        wpay  = rd_pay_b;
      end
      S_CHILD: begin
        if (child_ix < n_ext) begin
          re = 1'b1;
          ra = child_ix[AW-1:0];
          rb = (child1 < n_ext) ? child1[AW-1:0] : child_ix[AW-1:0];
        end else begin
          we    = 1'b1;
          waddr = parent;
          wkey  = hold_key;
          wpay  = hold_pay;
        end
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = parent;
        wkey  = take ? big_key : hold_key;
        wpay  = take ? big_pay : hold_pay;
      end
      S_OUT_RD: begin
        re = 1'b1;
        ra = k_reg;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    if (re) begin
      rd_key_a <= key_mem[ra];
      rd_pay_a <= pay_mem[ra];
      rd_key_b <= key_mem[rb];
      rd_pay_b <= pay_mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      item_count    <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != S_OUT_LD)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (item_valid) begin
            item_count <= load_count;
            if (full) begin
              overflow_seen <= 1'b1;
            end
            if (item.last) begin
              n_reg <= load_count;
              i_reg <= load_count >> 1;
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (i_reg != '0) begin
            i_reg <= i_reg - CW'(1);
            state <= S_HOLD;
          end else if (n_reg == CW'(1)) begin
            k_reg <= '0;
            state <= S_OUT_RD;
          end else begin
            n_reg <= n_reg - CW'(1);
            state <= S_SWAP;
          end
        end
        S_HOLD: begin
          hold_key <= rd_key_a;
          hold_pay <= rd_pay_a;
          parent   <= AW'(i_reg);
          state    <= S_CHILD;
        end
        S_SWAP: begin
          hold_key <= rd_key_a;
          hold_pay <= rd_pay_a;
          parent   <= '0;
          state    <= S_CHILD;
        end
        S_CHILD: begin
          if (child_ix < n_ext) begin
            child_reg <= child_ix[AW-1:0];
            right_in  <= (child1 < n_ext);
            state     <= S_CMP;
          end else begin
            state <= S_NEXT;
          end
        end
        S_CMP: begin
          if (take) begin
            parent <= big_ix;
            state  <= S_CHILD;
          end else begin
            state <= S_NEXT;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          if (out_free) begin
            res_valid                <= 1'b1;
            res_data.sorted_key      <= rd_key_a;
            res_data.sorted_payload  <= PAY_W'(rd_pay_a);
            res_data.final_res       <= last_k;
            res_data.dropped         <= overflow_seen;
            if (last_k) begin
              item_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= S_LOAD;
            end else begin
              k_reg <= k_reg + AW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CW'(MAX_ITEMS))
    else $error("item count beyond store depth");

  a_heap_size: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> ((n_reg <= item_count) && (n_reg != '0)))
    else $error("heap size out of range");

  a_sort_write: assert property (@(posedge clk) disable iff (rst)
    (we && (state != S_LOAD)) |-> (CW'(waddr) < item_count))
    else $error("sort write outside loaded entries");

  a_child_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (CW'(child_reg) < n_reg))
    else $error("child index outside heap");

  a_set_done: assert property (@(posedge clk) disable iff (rst)
    ((state == S_OUT_LD) && out_free && last_k) |=>
      ((state == S_LOAD) && (item_count == '0) && !overflow_seen && res_data.final_res))
    else $error("set not closed after final transaction");

endmodule
